### src/afbu_pkg.sv
// Package for the activation forward/backward unit: types, constants and table contents.
package afbu_pkg;

  // Fixed point format and table geometry
  localparam int FRAC_BITS      = 16;
  localparam int TABLE_SEGMENTS = 256;             // power of two
  localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
  localparam int SLOPE_W        = 17;
  localparam int XW             = 32;

  localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
  localparam longint Q31_ONE = longint'(1) << 31;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // Internal widths
  localparam int CW   = FRAC_BITS + 5;              // x clamped to +-8
  localparam int C2W  = FRAC_BITS + 8;              // c*c
  localparam int M1W  = FRAC_BITS + 11;             // c^3
  localparam int GW   = FRAC_BITS + 8;              // gelu intermediates
  localparam int KW   = FRAC_BITS + 1;              // gelu coefficients
  localparam int RW   = FRAC_BITS + 2;              // table entry (biased, unsigned)
  localparam int TW   = FRAC_BITS + 2;              // tanh / sigmoid value
  localparam int OFF  = FRAC_BITS + 4 - SEG_BITS;   // offset bits inside a segment
  localparam int LKW  = FRAC_BITS + 4;              // table position
  localparam int YW   = SLOPE_W + XW - FRAC_BITS + 1;
  localparam int DW   = FRAC_BITS + 9;              // derivative
  localparam int PW   = FRAC_BITS + 25;             // derivative times gradient
  localparam int SW   = PW + 1;                     // gradient sum before clipping
  localparam int NST  = 12;                         // pipeline stages before output

  typedef enum logic [2:0] {
    ACT_RELU  = 3'd0,
    ACT_TANH  = 3'd1,
    ACT_SIGM  = 3'd2,
    ACT_LEAKY = 3'd3,
    ACT_GELU  = 3'd4
  } act_e;

  typedef logic [RW-1:0] rom_t [0:TABLE_SEGMENTS];

  // Pipeline word, fields filled in as the item moves down
  typedef struct packed {
    logic [2:0]             req_type;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   g;
    logic signed [XW-1:0]   acc;
    logic signed [CW-1:0]   c;
    logic signed [C2W-1:0]  c2;
    logic signed [YW-1:0]   ya;
    logic signed [M1W-1:0]  m1;
    logic signed [GW-1:0]   bc;
    logic signed [GW-1:0]   m2;
    logic signed [GW-1:0]   u;
    logic [RW-1:0]          lo;
    logic signed [RW:0]     diff;
    logic [OFF-1:0]         frac;
    logic signed [TW-1:0]   t;
    logic signed [TW-1:0]   sq;
    logic signed [XW-1:0]   yg;
    logic signed [CW-1:0]   cs;
    logic signed [CW-1:0]   ck;
    logic signed [GW-1:0]   tail;
    logic signed [DW-1:0]   d;
    logic signed [YW-1:0]   y;
    logic signed [PW-1:0]   prod;
  } pipe_t;

  // Round to nearest, ties up: floor((v + 2^(s-1)) / 2^s)
  function automatic longint rnd_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Quotient of two non-negative values by shift and subtract (table build only)
  function automatic longint udiv(longint num, longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (longint'(1) << b);
      end
    end
    return quo;
  endfunction

  // e^-(r/q) in Q31 for 0 <= r <= q, Taylor series
  function automatic longint taylor_neg(longint r, longint q);
    longint sum;
    longint term;
    sum  = 0;
    term = Q31_ONE;
    for (int n = 0; n < 40; n++) begin
      if (term > 0) begin
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
        term = udiv(term * r, q * longint'(n + 1));
      end
    end
    return (sum < 0) ? 0 : sum;
  endfunction

  function automatic longint exp_neg(longint p, longint q);
    longint k;
    longint v;
    longint e1;
    k  = udiv(p, q);
    v  = taylor_neg(p - k * q, q);
    e1 = taylor_neg(1, 1);
    for (longint j = 0; j < k; j++) begin
      v = (v * e1 + (longint'(1) << 30)) >>> 31;
    end
    return v;
  endfunction

  function automatic longint q31_to_fx(longint v);
    return (v * ONE_FX + (longint'(1) << 30)) >>> 31;
  endfunction

  // Table samples on x_i = -8 + 16*i/TABLE_SEGMENTS; tanh is stored biased by one
  function automatic rom_t build_rom(bit sigm);
    rom_t   r;
    longint d;
    longint m;
    longint e2;
    longint e1;
    longint th;
    longint den;
    longint sg;
    for (int i = 0; i <= TABLE_SEGMENTS; i++) begin
      d   = 16 * longint'(i) - 8 * longint'(TABLE_SEGMENTS);
      m   = (d < 0) ? -d : d;
      e2  = exp_neg(2 * m, TABLE_SEGMENTS);
      e1  = exp_neg(m, TABLE_SEGMENTS);
      th  = q31_to_fx(udiv((Q31_ONE - e2) << 31, Q31_ONE + e2));
      den = Q31_ONE + e1;
      sg  = q31_to_fx(udiv((Q31_ONE << 31) + (den >>> 1), den));
      if (sigm) r[i] = RW'((d < 0) ? ONE_FX - sg : sg);
      else r[i] = RW'(((d < 0) ? -th : th) + ONE_FX);
    end
    return r;
  endfunction

  localparam rom_t TANH_ROM = build_rom(1'b0);
  localparam rom_t SIGM_ROM = build_rom(1'b1);

  // sqrt(2/pi), 0.044715 and 3*0.044715 from Q30
  localparam logic signed [KW-1:0] KQ = KW'(rnd_shr(856722024, 30 - FRAC_BITS));
  localparam logic signed [KW-1:0] AQ = KW'(rnd_shr(48012366, 30 - FRAC_BITS));
  localparam logic signed [KW-1:0] BQ = KW'(rnd_shr(144037097, 30 - FRAC_BITS));

endpackage

### src/activation_forward_backward_unit.sv
// Activation forward/backward unit: pipelined f(x) and gradient accumulation.
//
// Input channel: in_valid_i / in_stall_o with req_type_i, x_value_i, upstream_grad_i
// and grad_sum_in_i. A transaction is taken at a clock edge with in_valid_i high
// and in_stall_o low. Output channel: out_valid_o / out_stall_i with y_value_o,
// grad_sum_out_o and saturated_o; every input transaction yields one output.
// Configuration: cfg_we_i writes cfg_wdata_i into the leaky relu slope; write it
// only while no transaction is in flight.
// Acceptance to out_valid_o passes through twelve pipeline stages and an output
// register, each holding at most two multipliers; throughput is one transaction
// per cycle while in_stall_o is low. The gelu chain (cube, tanh lookup, tail)
// is what fixes the depth.
// A stalled output holds its data; stages behind it keep filling empty slots,
// and in_stall_o rises only when every stage is occupied.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the slope
// with 655 (about 0.01). The tanh and sigmoid tables are constant logic.
module activation_forward_backward_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [afbu_pkg::SLOPE_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          req_type_i,
  input  logic signed [afbu_pkg::XW-1:0]      x_value_i,
  input  logic signed [afbu_pkg::XW-1:0]      upstream_grad_i,
  input  logic signed [afbu_pkg::XW-1:0]      grad_sum_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [afbu_pkg::XW-1:0]      y_value_o,
  output logic signed [afbu_pkg::XW-1:0]      grad_sum_out_o,
  output logic                                saturated_o
);

  localparam int F   = afbu_pkg::FRAC_BITS;
  localparam int NST = afbu_pkg::NST;
  localparam int XW  = afbu_pkg::XW;
  localparam int CW  = afbu_pkg::CW;
  localparam int C2W = afbu_pkg::C2W;
  localparam int M1W = afbu_pkg::M1W;
  localparam int GW  = afbu_pkg::GW;
  localparam int KW  = afbu_pkg::KW;
  localparam int RW  = afbu_pkg::RW;
  localparam int TW  = afbu_pkg::TW;
  localparam int OFF = afbu_pkg::OFF;
  localparam int LKW = afbu_pkg::LKW;
  localparam int YW  = afbu_pkg::YW;
  localparam int DW  = afbu_pkg::DW;
  localparam int PW  = afbu_pkg::PW;
  localparam int SW  = afbu_pkg::SW;
  localparam int SB  = afbu_pkg::SEG_BITS;

  localparam longint ONE   = afbu_pkg::ONE_FX;
  localparam longint EIGHT = afbu_pkg::ONE_FX * 8;

  // Configuration register
  logic [afbu_pkg::SLOPE_W-1:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= afbu_pkg::SLOPE_W'(655);
    end else if (cfg_we_i) begin
      slope_q <= cfg_wdata_i;
    end
  end

  // Pipeline state
  afbu_pkg::pipe_t       st_q [NST];
  afbu_pkg::pipe_t       st_d [NST];
  logic [NST-1:0]        v_q;
  logic [NST-1:0]        en_s;
  logic                  en_out;

  logic signed [XW-1:0]  y_q, y_d;
  logic signed [XW-1:0]  sum_q, sum_d;
  logic                  sat_q, sat_d;
  logic                  out_vld_q;

  // Advance control: a stage loads when empty or when the next one loads
  always_comb begin
    en_out        = !out_vld_q || !out_stall_i;
    en_s[NST-1]   = !v_q[NST-1] || en_out;
    for (int k = NST - 2; k >= 0; k--) begin
      en_s[k] = !v_q[k] || en_s[k+1];
    end
  end

  assign in_stall_o = !en_s[0];

  // Stage 0: clamp, c*c, leaky product
  logic signed [CW-1:0]       c_in;
  logic signed [2*CW-1:0]     p_c2;
  logic signed [afbu_pkg::SLOPE_W+XW:0] p_ya;
  // Stage 1: c^3 and B*c^2
  logic signed [C2W+CW-1:0]   p_m1;
  logic signed [KW+C2W-1:0]   p_bc;
  // Stage 2: A*c^3
  logic signed [KW+M1W-1:0]   p_m2;
  // Stage 3: K*(c + A*c^3)
  logic signed [GW:0]         s_cu;
  logic signed [KW+GW:0]      p_u;
  // Stage 4: table addressing
  logic signed [XW-1:0]       lk_v;
  logic [LKW-1:0]             lk_w;
  logic [SB:0]                lk_i0, lk_i1;
  logic                       lk_low, lk_high, lk_tanh;
  logic [RW-1:0]              r0, r1;
  // Stage 5: interpolation
  logic signed [RW+OFF+1:0]   p_it;
  // Stage 6: squares and gelu output
  logic signed [TW-1:0]       sq_b;
  logic signed [2*TW-1:0]     p_sq;
  logic signed [XW+F+2:0]     p_yg;
  // Stage 7..9: gelu derivative tail
  logic signed [TW-1:0]       sech;
  logic signed [CW+TW-1:0]    p_cs;
  logic signed [CW+KW-1:0]    p_ck;
  logic signed [GW:0]         bc1;
  logic signed [CW+GW:0]      p_tail;
  // Stage 11: derivative times gradient
  logic signed [DW+XW-1:0]    p_dg;
  // Output: clipping
  logic signed [SW-1:0]       sum_w;

  always_comb begin
    // stage 0
    if (x_value_i > XW'(EIGHT)) c_in = CW'(EIGHT);
    else if (x_value_i < XW'(-EIGHT)) c_in = CW'(-EIGHT);
    else c_in = CW'(x_value_i);
    p_c2 = c_in * c_in;
    p_ya = $signed({1'b0, slope_q}) * x_value_i;

    st_d[0]          = st_q[0];
    st_d[0].req_type = req_type_i;
    st_d[0].x        = x_value_i;
    st_d[0].g        = upstream_grad_i;
    st_d[0].acc      = grad_sum_in_i;
    st_d[0].c        = c_in;
    st_d[0].c2       = C2W'(afbu_pkg::rnd_shr(longint'(p_c2), F));
    st_d[0].ya       = YW'(afbu_pkg::rnd_shr(longint'(p_ya), F));

    // stage 1
    p_m1 = st_q[0].c2 * st_q[0].c;
    p_bc = afbu_pkg::BQ * st_q[0].c2;
    st_d[1]    = st_q[0];
    st_d[1].m1 = M1W'(afbu_pkg::rnd_shr(longint'(p_m1), F));
    st_d[1].bc = GW'(afbu_pkg::rnd_shr(longint'(p_bc), F));

    // stage 2
    p_m2 = afbu_pkg::AQ * st_q[1].m1;
    st_d[2]    = st_q[1];
    st_d[2].m2 = GW'(afbu_pkg::rnd_shr(longint'(p_m2), F));

    // stage 3
    s_cu = (GW+1)'(st_q[2].c) + (GW+1)'(st_q[2].m2);
    p_u  = afbu_pkg::KQ * s_cu;
    st_d[3]   = st_q[2];
    st_d[3].u = GW'(afbu_pkg::rnd_shr(longint'(p_u), F));

    // stage 4: pick the argument, clamp to the table ends, read two samples
    lk_tanh = (st_q[3].req_type == afbu_pkg::ACT_TANH) ||
              (st_q[3].req_type == afbu_pkg::ACT_GELU);
    lk_v    = (st_q[3].req_type == afbu_pkg::ACT_GELU) ? XW'(st_q[3].u) : st_q[3].x;
    lk_low  = lk_v <= XW'(-EIGHT);
    lk_high = lk_v >= XW'(EIGHT);
    lk_w    = LKW'(lk_v + XW'(EIGHT));
    lk_i0   = (SB+1)'(lk_w[LKW-1:OFF]);
    lk_i1   = lk_i0 + (SB+1)'(1);
    if (lk_low) begin
      lk_i0 = '0;
      lk_i1 = '0;
    end else if (lk_high) begin
      lk_i0 = (SB+1)'(afbu_pkg::TABLE_SEGMENTS);
      lk_i1 = (SB+1)'(afbu_pkg::TABLE_SEGMENTS);
    end
    r0 = lk_tanh ? afbu_pkg::TANH_ROM[lk_i0] : afbu_pkg::SIGM_ROM[lk_i0];
    r1 = lk_tanh ? afbu_pkg::TANH_ROM[lk_i1] : afbu_pkg::SIGM_ROM[lk_i1];
    st_d[4]      = st_q[3];
    st_d[4].lo   = r0;
    st_d[4].diff = $signed({1'b0, r1}) - $signed({1'b0, r0});
    st_d[4].frac = lk_w[OFF-1:0];

    // stage 5: linear interpolation, remove the tanh bias
    p_it = st_q[4].diff * $signed({1'b0, st_q[4].frac});
    st_d[5]   = st_q[4];
    st_d[5].t = TW'(longint'(st_q[4].lo) + afbu_pkg::rnd_shr(longint'(p_it), OFF)
                    - (((st_q[4].req_type == afbu_pkg::ACT_SIGM)) ? 0 : ONE));

    // stage 6: t*t (or s*(1-s)) and gelu output x*(1+t)/2
    sq_b = (st_q[5].req_type == afbu_pkg::ACT_SIGM) ?
           TW'(ONE - longint'(st_q[5].t)) : st_q[5].t;
    p_sq = st_q[5].t * sq_b;
    p_yg = st_q[5].x * (F+3)'(ONE + longint'(st_q[5].t));
    st_d[6]    = st_q[5];
    st_d[6].sq = TW'(afbu_pkg::rnd_shr(longint'(p_sq), F));
    st_d[6].yg = XW'(afbu_pkg::rnd_shr(longint'(p_yg), F + 1));

    // stage 7: c * sech^2
    sech = TW'(ONE - longint'(st_q[6].sq));
    p_cs = st_q[6].c * sech;
    st_d[7]    = st_q[6];
    st_d[7].cs = CW'(afbu_pkg::rnd_shr(longint'(p_cs), F));

    // stage 8: times K
    p_ck = st_q[7].cs * afbu_pkg::KQ;
    st_d[8]    = st_q[7];
    st_d[8].ck = CW'(afbu_pkg::rnd_shr(longint'(p_ck), F));

    // stage 9: times (1 + B*c^2)
    bc1    = (GW+1)'(ONE) + (GW+1)'(st_q[8].bc);
    p_tail = st_q[8].ck * bc1;
    st_d[9]      = st_q[8];
    st_d[9].tail = GW'(afbu_pkg::rnd_shr(longint'(p_tail), F));

    // stage 10: select f(x) and f'(x)
    st_d[10] = st_q[9];
    case (st_q[9].req_type)
      afbu_pkg::ACT_RELU: begin
        st_d[10].y = (st_q[9].x > 0) ? YW'(st_q[9].x) : '0;
        st_d[10].d = (st_q[9].x > 0) ? DW'(ONE) : '0;
      end
      afbu_pkg::ACT_TANH: begin
        st_d[10].y = YW'(st_q[9].t);
        st_d[10].d = DW'(ONE - longint'(st_q[9].sq));
      end
      afbu_pkg::ACT_SIGM: begin
        st_d[10].y = YW'(st_q[9].t);
        st_d[10].d = DW'(st_q[9].sq);
      end
      afbu_pkg::ACT_LEAKY: begin
        st_d[10].y = (st_q[9].x > 0) ? YW'(st_q[9].x) : st_q[9].ya;
        st_d[10].d = (st_q[9].x > 0) ? DW'(ONE) : DW'(slope_q);
      end
      afbu_pkg::ACT_GELU: begin
        st_d[10].y = YW'(st_q[9].yg);
        st_d[10].d = DW'(afbu_pkg::rnd_shr(ONE + longint'(st_q[9].t)
                                           + longint'(st_q[9].tail), 1));
      end
      default: begin
        st_d[10].y = '0;
        st_d[10].d = '0;
      end
    endcase

    // stage 11: derivative times upstream gradient
    p_dg = st_q[10].d * st_q[10].g;
    st_d[11]      = st_q[10];
    st_d[11].prod = PW'(afbu_pkg::rnd_shr(longint'(p_dg), F));

    // output: accumulate and clip
    sum_w = SW'(st_q[11].acc) + SW'(st_q[11].prod);
    sat_d = 1'b0;
    if (st_q[11].y > YW'(afbu_pkg::I32_MAX)) begin
      y_d   = XW'(afbu_pkg::I32_MAX);
      sat_d = 1'b1;
    end else if (st_q[11].y < YW'(afbu_pkg::I32_MIN)) begin
      y_d   = XW'(afbu_pkg::I32_MIN);
      sat_d = 1'b1;
    end else begin
      y_d = XW'(st_q[11].y);
    end
    if (sum_w > SW'(afbu_pkg::I32_MAX)) begin
      sum_d = XW'(afbu_pkg::I32_MAX);
      sat_d = 1'b1;
    end else if (sum_w < SW'(afbu_pkg::I32_MIN)) begin
      sum_d = XW'(afbu_pkg::I32_MIN);
      sat_d = 1'b1;
    end else begin
      sum_d = XW'(sum_w);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en_s[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en_s[k]) v_q[k] <= v_q[k-1];
      end
      if (en_out) out_vld_q <= v_q[NST-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en_s[k]) st_q[k] <= st_d[k];
    end
    if (en_out) begin
      y_q   <= y_d;
      sum_q <= sum_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign y_value_o      = y_q;
  assign grad_sum_out_o = sum_q;
  assign saturated_o    = sat_q;

  // Input backs up only when every stage and the output hold a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_valid_o))
    else $error("input stalled with a free pipeline slot");

  // A transaction in the last stage follows a taken output
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && v_q[NST-1]) |=> out_valid_o)
    else $error("transaction lost between last stage and output");

  // The flag only accompanies a clipped value
  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (y_value_o == XW'(afbu_pkg::I32_MAX) || y_value_o == XW'(afbu_pkg::I32_MIN) ||
       grad_sum_out_o == XW'(afbu_pkg::I32_MAX) ||
       grad_sum_out_o == XW'(afbu_pkg::I32_MIN)))
    else $error("saturation flag without a clipped value");

endmodule

### tb/tb_activation_forward_backward_unit.sv
// Testbench for the activation forward/backward unit: random and directed items, scoreboard.
module tb_activation_forward_backward_unit;

  localparam int     TABS       = 256;
  localparam longint UNIT       = longint'(1) << 16;
  localparam longint Q31_UNIT   = longint'(1) << 31;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     DRAIN_WAIT = 16;

  typedef struct {
    logic signed [31:0] y_value;
    logic signed [31:0] grad_sum;
    logic               saturated;
  } act_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [afbu_pkg::SLOPE_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         req_type_i;
  logic signed [31:0] x_value_i;
  logic signed [31:0] upstream_grad_i;
  logic signed [31:0] grad_sum_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] y_value_o;
  logic signed [31:0] grad_sum_out_o;
  logic               saturated_o;

  activation_forward_backward_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .x_value_i      (x_value_i),
    .upstream_grad_i(upstream_grad_i),
    .grad_sum_in_i  (grad_sum_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .y_value_o      (y_value_o),
    .grad_sum_out_o (grad_sum_out_o),
    .saturated_o    (saturated_o)
  );

  // Model state: tables, slope, pending results
  longint      tanh_tab [0:TABS];
  longint      sigm_tab [0:TABS];
  longint      slope_model;
  act_result_t pending_results[$];
  int          error_count;
  int          sent_count;
  int          result_count;
  int          sat_count;
  int          type_count [0:7];
  int          cycle_count;
  bit          idle_en;

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Round to nearest, ties up
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_shift(a * b, 16);
  endfunction

  // e^-(r/q) in Q31 by series, 0 <= r <= q
  function automatic longint series_exp(longint r, longint q);
    longint acc;
    longint term;
    acc  = 0;
    term = Q31_UNIT;
    for (int n = 0; n < 40; n++) begin
      if (term > 0) begin
        acc  = (n % 2 == 1) ? acc - term : acc + term;
        term = term * r / (q * longint'(n + 1));
      end
    end
    return (acc < 0) ? 0 : acc;
  endfunction

  function automatic longint decay_q31(longint p, longint q);
    longint v;
    longint e1;
    v  = series_exp(p % q, q);
    e1 = series_exp(1, 1);
    for (longint j = 0; j < p / q; j++) v = (v * e1 + (longint'(1) << 30)) >>> 31;
    return v;
  endfunction

  function automatic longint q31_to_q16(longint v);
    return (v * UNIT + (longint'(1) << 30)) >>> 31;
  endfunction

  // Fill both lookup tables; tanh is stored biased by one
  function automatic void fill_tables();
    longint d, m, e2, e1, th, den, sg;
    for (int i = 0; i <= TABS; i++) begin
      d   = 16 * longint'(i) - 8 * longint'(TABS);
      m   = (d < 0) ? -d : d;
      e2  = decay_q31(2 * m, TABS);
      e1  = decay_q31(m, TABS);
      th  = q31_to_q16(((Q31_UNIT - e2) << 31) / (Q31_UNIT + e2));
      den = Q31_UNIT + e1;
      sg  = q31_to_q16(((Q31_UNIT << 31) + den / 2) / den);
      tanh_tab[i] = ((d < 0) ? -th : th) + UNIT;
      sigm_tab[i] = (d < 0) ? UNIT - sg : sg;
    end
  endfunction

  // Interpolated table value, clamped outside +-8
  function automatic longint table_value(bit use_sigm, longint v);
    longint span, pos, idx, rem, lo, hi, bias;
    span = 16 * UNIT;
    bias = use_sigm ? 0 : UNIT;
    if (v <= -8 * UNIT) idx = 0;
    else if (v >= 8 * UNIT) idx = TABS;
    else begin
      pos = (v + 8 * UNIT) * TABS;
      idx = pos / span;
      rem = pos % span;
    end
    if (v <= -8 * UNIT || v >= 8 * UNIT || idx >= TABS)
      return (use_sigm ? sigm_tab[idx] : tanh_tab[idx]) - bias;
    lo = use_sigm ? sigm_tab[idx] : tanh_tab[idx];
    hi = use_sigm ? sigm_tab[idx + 1] : tanh_tab[idx + 1];
    return (lo * (span - rem) + hi * rem + span / 2) / span - bias;
  endfunction

  function automatic longint clip32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Expected forward value and updated gradient sum for one transaction
  function automatic act_result_t predict_activation(logic [2:0] kind, longint x, longint g,
                                                     longint s);
    act_result_t r;
    longint y, d, t, kq, aq, bq, c, c2, u, sech, tail, sum;
    bit flag;
    y    = 0;
    d    = 0;
    flag = 1'b0;
    case (kind)
      afbu_pkg::ACT_RELU: begin
        y = (x > 0) ? x : 0;
        d = (x > 0) ? UNIT : 0;
      end
      afbu_pkg::ACT_TANH: begin
        t = table_value(1'b0, x);
        y = t;
        d = UNIT - fx_mul(t, t);
      end
      afbu_pkg::ACT_SIGM: begin
        t = table_value(1'b1, x);
        y = t;
        d = fx_mul(t, UNIT - t);
      end
      afbu_pkg::ACT_LEAKY: begin
        y = (x > 0) ? x : fx_mul(slope_model, x);
        d = (x > 0) ? UNIT : slope_model;
      end
      afbu_pkg::ACT_GELU: begin
        kq   = round_shift(856722024, 14);
        aq   = round_shift(48012366, 14);
        bq   = round_shift(144037097, 14);
        c    = (x > 8 * UNIT) ? 8 * UNIT : ((x < -8 * UNIT) ? -8 * UNIT : x);
        c2   = fx_mul(c, c);
        u    = fx_mul(kq, c + fx_mul(aq, fx_mul(c2, c)));
        t    = table_value(1'b0, u);
        y    = round_shift(x * (UNIT + t), 17);
        sech = UNIT - fx_mul(t, t);
        tail = fx_mul(fx_mul(fx_mul(c, sech), kq), UNIT + fx_mul(bq, c2));
        d    = round_shift((UNIT + t) + tail, 1);
      end
      default: begin
        y = 0;
        d = 0;
      end
    endcase
    sum         = s + round_shift(d * g, 16);
    r.y_value   = 32'(clip32(y, flag));
    r.grad_sum  = 32'(clip32(sum, flag));
    r.saturated = flag;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int rand_gap();
    int p;
    if (!idle_en) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Values near the table range, near +-8, or anywhere
  function automatic logic signed [31:0] rand_x();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
    if (p < 7) return 32'(($urandom_range(0, 1) ? 8 : -8) * 65536 +
                         $signed($urandom_range(0, 64)) - 32);
    return 32'($urandom);
  endfunction

  function automatic logic signed [31:0] rand_wide_or_small();
    if ($urandom_range(0, 2) == 0) return 32'($urandom);
    return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
  endfunction

  // Output stall, random while idling is on
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= (rand_gap() != 0);
  end

  // Result checker
  always @(posedge clk_i) begin
    act_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (saturated_o) sat_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result y=%0d sum=%0d sat=%0b", $time, y_value_o,
                 grad_sum_out_o, saturated_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (y_value_o !== want.y_value) begin
          $display("%0t: y_value expected %0d actual %0d", $time, want.y_value, y_value_o);
          error_count++;
        end
        if (grad_sum_out_o !== want.grad_sum) begin
          $display("%0t: grad_sum_out expected %0d actual %0d", $time, want.grad_sum,
                   grad_sum_out_o);
          error_count++;
        end
        if (saturated_o !== want.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                   saturated_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one transaction and hold it until accepted
  task automatic send_item(logic [2:0] kind, logic signed [31:0] x, logic signed [31:0] g,
                           logic signed [31:0] s);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    req_type_i      = kind;
    x_value_i       = x;
    upstream_grad_i = g;
    grad_sum_in_i   = s;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.insert(pending_results.size(), predict_activation(kind, x, g, s));
    sent_count++;
    type_count[kind]++;
  endtask

  // Wait until every transaction has come out and the pipe is empty
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_slope(logic [afbu_pkg::SLOPE_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    slope_model = value;
  endtask

  // Edges of each activation, unused selectors, saturation
  task automatic test_directed();
    logic signed [31:0] xs [0:4];
    xs = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd524288, 32'sd524288};
    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 5; i++) send_item(3'(k), xs[i], 32'sd65536, 32'sd0);
    end
    send_item(afbu_pkg::ACT_RELU, 32'sd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(afbu_pkg::ACT_RELU, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(3'd5, 32'sd12345, 32'sd7, -32'sd99);
    send_item(3'd6, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(3'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
  endtask

  // Slope extremes, including saturating leaky results
  task automatic test_slope_extremes();
    logic [afbu_pkg::SLOPE_W-1:0] slopes [0:3];
    slopes = '{17'd0, 17'd65536, 17'h1FFFF, 17'd655};
    for (int k = 0; k < 4; k++) begin
      write_slope(slopes[k]);
      send_item(afbu_pkg::ACT_LEAKY, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_item(afbu_pkg::ACT_LEAKY, -32'sd65536, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_item(afbu_pkg::ACT_LEAKY, -32'sd3, rand_wide_or_small(), rand_wide_or_small());
    end
  endtask

  // Random items over several slope settings, idling on and off
  task automatic test_random(int count);
    logic [2:0] kind;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) write_slope(($urandom_range(0, 3) == 0) ? 17'($urandom) :
                                    17'($urandom_range(0, 65536)));
      if (i % 200 == 0) idle_en = ($urandom_range(0, 3) != 0);
      kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      send_item(kind, rand_x(), rand_wide_or_small(), rand_wide_or_small());
    end
    idle_en = 1'b1;
  endtask

  // Sender holds off until every pending result is back, then restarts
  task automatic test_hold_off();
    for (int i = 0; i < 20; i++) send_item(3'($urandom_range(0, 4)), rand_x(), 32'($urandom),
                                           32'($urandom));
    drain();
    for (int i = 0; i < 20; i++) send_item(3'($urandom_range(0, 4)), rand_x(), 32'($urandom),
                                           32'($urandom));
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    req_type_i      = '0;
    x_value_i       = '0;
    upstream_grad_i = '0;
    grad_sum_in_i   = '0;
    error_count     = 0;
    sent_count      = 0;
    result_count    = 0;
    sat_count       = 0;
    cycle_count     = 0;
    idle_en         = 1'b1;
    slope_model     = 655;
    for (int k = 0; k < 8; k++) type_count[k] = 0;
    fill_tables();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_slope_extremes();
    test_hold_off();
    test_random(1000);
    drain();

    $display("Sent %0d transactions, %0d results checked, %0d saturated.", sent_count,
             result_count, sat_count);
    $display("Per selector: relu %0d tanh %0d sigm %0d leaky %0d gelu %0d unused %0d",
             type_count[0], type_count[1], type_count[2], type_count[3], type_count[4],
             type_count[5] + type_count[6] + type_count[7]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
